// File: design/omni_wheel_motion_mixer_core_assert.svh
// assertion macros used by the mixer core rtl
`ifndef OMNI_WHEEL_MOTION_MIXER_CORE_ASSERT_SVH
`define OMNI_WHEEL_MOTION_MIXER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define OWM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define OWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: design/omwm_pkg.sv
package omwm_pkg;

   localparam int CORDIC_STAGES = 14;
   localparam int CORDIC_N = (CORDIC_STAGES > 20) ? 20 : CORDIC_STAGES;

   localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
   localparam logic signed [16:0] DEG90 = 17'sd5760;
   localparam logic signed [16:0] DEG180 = 17'sd11520;
   localparam logic signed [16:0] DEG270 = 17'sd17280;
   localparam logic signed [16:0] DEG360 = 17'sd23040;
   localparam logic signed [23:0] Z_LIMIT = 24'sd1474560;

   localparam logic [3:0] KIND_STOP = 4'd0;
   localparam logic [3:0] KIND_FWD = 4'd1;
   localparam logic [3:0] KIND_BACK = 4'd2;
   localparam logic [3:0] KIND_LEFT = 4'd3;
   localparam logic [3:0] KIND_RIGHT = 4'd4;
   localparam logic [3:0] KIND_CW = 4'd5;
   localparam logic [3:0] KIND_CCW = 4'd6;
   localparam logic [3:0] KIND_AIM = 4'd7;
   localparam logic [3:0] KIND_TRACK = 4'd8;

   localparam logic [3:0] REG_W1_SINE = 4'd0;
   localparam logic [3:0] REG_W1_COSINE = 4'd1;
   localparam logic [3:0] REG_W2_SINE = 4'd2;
   localparam logic [3:0] REG_W2_COSINE = 4'd3;
   localparam logic [3:0] REG_W3_SINE = 4'd4;
   localparam logic [3:0] REG_W3_COSINE = 4'd5;
   localparam logic [3:0] REG_BODY_RADIUS = 4'd6;
   localparam logic [3:0] REG_COUNT_SCALE = 4'd7;

   typedef struct packed {
      logic [3:0] kind;
      logic signed [15:0] speed;
      logic signed [15:0] gyro;
      logic neg;
   } cmd_type;

   // load enables of the four per-wheel stages
   typedef struct packed {
      logic mul;
      logic sum;
      logic part;
      logic fin;
   } wheel_en_type;

   function automatic logic signed [23:0] atan_val(input int idx);
      logic signed [23:0] v;
      case (idx)
         0: v = 24'sd737280;
         1: v = 24'sd435242;
         2: v = 24'sd229970;
         3: v = 24'sd116736;
         4: v = 24'sd58595;
         5: v = 24'sd29326;
         6: v = 24'sd14667;
         7: v = 24'sd7334;
         8: v = 24'sd3667;
         9: v = 24'sd1833;
         10: v = 24'sd917;
         11: v = 24'sd458;
         12: v = 24'sd229;
         13: v = 24'sd115;
         14: v = 24'sd57;
         15: v = 24'sd29;
         16: v = 24'sd14;
         17: v = 24'sd7;
         18: v = 24'sd4;
         19: v = 24'sd2;
         default: v = 24'sd0;
      endcase
      return v;
   endfunction

endpackage

// File: design/omwm_wheel.sv
module omwm_wheel (
   input  logic clock,
   input  omwm_pkg::wheel_en_type en,
   input  logic signed [31:0] vx,
   input  logic signed [31:0] vy,
   input  logic signed [33:0] rw,
   input  logic signed [15:0] sine,
   input  logic signed [15:0] cosine,
   input  logic [31:0] scale,
   output logic signed [15:0] count
);
   import omwm_pkg::*;

   logic signed [47:0] p1_ff, p2_ff;
   logic signed [33:0] rw_ff;
   logic signed [49:0] w_in;
   logic [49:0] m_in;
   logic [48:0] m_ff;
   logic neg_ff, neg2_ff;
   logic [57:0] pa_ff;
   logic [55:0] pb_ff;
   logic [58:0] acc;
   logic [26:0] q;
   logic signed [15:0] count_ff, count_in;

   always_comb begin
      w_in = 50'(p2_ff) - 50'(p1_ff) + (50'(rw_ff) <<< 16);
      m_in = w_in[49] ? 50'(-w_in) : 50'(w_in);
   end

   always_ff @(posedge clock) begin
      if (en.mul) begin
         p1_ff <= vx * sine;
         p2_ff <= vy * cosine;
         rw_ff <= rw;
      end
      if (en.sum) begin
         m_ff <= m_in[48:0];
         neg_ff <= w_in[49];
      end
      if (en.part) begin
         pa_ff <= 26'(m_ff[48:24]) * scale;
         pb_ff <= m_ff[23:0] * scale;
         neg2_ff <= neg_ff;
      end
      if (en.fin) begin
         count_ff <= count_in;
      end
   end

   // exact truncation of m * scale / 2^56 from two partial products, then sign and 16-bit saturation
   always_comb begin
      acc = 59'(pa_ff) + 59'(pb_ff >> 24);
      q = acc[58:32];
      if (neg2_ff) begin
         count_in = (q > 27'd32768) ? -16'sd32768 : 16'(-q);
      end else begin
         count_in = (q > 27'd32767) ? 16'sd32767 : 16'(q);
      end
   end

   assign count = count_ff;

endmodule

// File: design/omni_wheel_motion_mixer_core.sv
// three wheel omni base mixer: turns one motion command into three wheel speed
// targets in encoder counts.
// req channel: kind, speed, gyro, yaw; a transaction moves at a clock edge
// with req_valid high and req_stall low.
// rsp channel: wheel1..3_count, one transaction per command, in order.
// csr channel: csr_index / csr_data written when csr_valid and csr_ready are
// high; csr_ready is always high; write only while the pipeline is empty.
// stage registers from accept to rsp_valid, in order: input fold, one register
// per cordic iteration, round, velocity, wheel products, wheel sum, two partial
// scale products, saturation.
// throughput: one command per cycle unless a full pipe is held by rsp_stall;
// every stage register has its own valid bit and loads whenever it is empty or
// the stage after it moves, so bubbles close up under a stall.
// when rsp_stall is high the result holds on the rsp ports and the pipe keeps
// filling; req_stall rises only once every stage holds a command.
// reset: synchronous, clears all valid bits and restores the register defaults.
module omni_wheel_motion_mixer_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [3:0] req_kind,
   input  logic signed [15:0] req_speed,
   input  logic signed [15:0] req_gyro,
   input  logic signed [15:0] req_yaw,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [15:0] rsp_wheel1_count,
   output logic signed [15:0] rsp_wheel2_count,
   output logic signed [15:0] rsp_wheel3_count,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [3:0] csr_index,
   input  logic [31:0] csr_data
);
   import omwm_pkg::*;

   `include "omni_wheel_motion_mixer_core_assert.svh"

   localparam int N = CORDIC_N;
   localparam int ROUND_ST = N + 1;
   localparam int VEL_ST = N + 2;
   localparam int MUL_ST = N + 3;
   localparam int SUM_ST = N + 4;
   localparam int PART_ST = N + 5;
   localparam int FIN_ST = N + 6;
   localparam int NS = N + 7;

   // configuration
   logic signed [15:0] w1s_ff, w1c_ff, w2s_ff, w2c_ff, w3s_ff, w3c_ff;
   logic [15:0] radius_ff;
   logic [31:0] scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         w1s_ff <= 16'sd0;
         w1c_ff <= 16'sd16384;
         w2s_ff <= 16'sd14189;
         w2c_ff <= -16'sd8192;
         w3s_ff <= -16'sd14189;
         w3c_ff <= -16'sd8192;
         radius_ff <= 16'd819;
         scale_ff <= 32'd65536;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_W1_SINE: w1s_ff <= csr_data[15:0];
            REG_W1_COSINE: w1c_ff <= csr_data[15:0];
            REG_W2_SINE: w2s_ff <= csr_data[15:0];
            REG_W2_COSINE: w2c_ff <= csr_data[15:0];
            REG_W3_SINE: w3s_ff <= csr_data[15:0];
            REG_W3_COSINE: w3c_ff <= csr_data[15:0];
            REG_BODY_RADIUS: radius_ff <= csr_data[15:0];
            REG_COUNT_SCALE: scale_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // valid chain and per-stage load enables
   logic [NS-1:0] valid_ff;
   logic en [0:NS];

   always_comb begin
      en[NS] = !rsp_stall;
      for (int s = NS - 1; s >= 0; s--) begin
         en[s] = !valid_ff[s] || en[s+1];
      end
   end

   assign req_stall = !en[0];
   assign rsp_valid = valid_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NS; s++) begin
            if (en[s]) begin
               valid_ff[s] <= (s == 0) ? req_valid : valid_ff[(s == 0) ? 0 : s - 1];
            end
         end
      end
   end

   // input stage: reduce yaw to one turn, fold into (-90, 90] degrees
   logic signed [16:0] yaw_ext, r_a, r_b, r_in;
   logic neg_in;
   logic signed [23:0] z_in;

   always_comb begin
      yaw_ext = 17'(req_yaw);
      r_a = (yaw_ext < 0) ? yaw_ext + DEG360 : yaw_ext;
      r_b = (r_a < 0) ? r_a + DEG360 : r_a;
      if (yaw_ext >= DEG360) r_b = yaw_ext - DEG360;
      neg_in = 1'b0;
      r_in = r_b;
      if (r_b > DEG90 && r_b <= DEG270) begin
         r_in = r_b - DEG180;
         neg_in = 1'b1;
      end else if (r_b > DEG270) begin
         r_in = r_b - DEG360;
      end
      z_in = 24'(r_in) <<< 8;
   end

   cmd_type cmd_ff [0:N+1];
   logic signed [32:0] cx_ff [0:N];
   logic signed [32:0] cy_ff [0:N];
   logic signed [23:0] cz_ff [0:N];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         cmd_ff[0] <= '{kind: req_kind, speed: req_speed, gyro: req_gyro, neg: neg_in};
         cx_ff[0] <= CORDIC_X0;
         cy_ff[0] <= 33'sd0;
         cz_ff[0] <= z_in;
      end
   end

   for (genvar g = 0; g < N; g++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (en[g+1]) begin
            cmd_ff[g+1] <= cmd_ff[g];
            if (cz_ff[g] >= 0) begin
               cx_ff[g+1] <= cx_ff[g] - (cy_ff[g] >>> g);
               cy_ff[g+1] <= cy_ff[g] + (cx_ff[g] >>> g);
               cz_ff[g+1] <= cz_ff[g] - atan_val(g);
            end else begin
               cx_ff[g+1] <= cx_ff[g] + (cy_ff[g] >>> g);
               cy_ff[g+1] <= cy_ff[g] - (cx_ff[g] >>> g);
               cz_ff[g+1] <= cz_ff[g] + atan_val(g);
            end
         end
      end
   end

   // round Q.30 to Q2.14, clamp, undo the half-turn fold
   logic signed [32:0] rx, ry;
   logic signed [15:0] cs_in, sn_in, cs_ff, sn_ff;

   always_comb begin
      rx = (cx_ff[N] + 33'sd32768) >>> 16;
      ry = (cy_ff[N] + 33'sd32768) >>> 16;
      if (rx > 33'sd16384) rx = 33'sd16384;
      if (rx < -33'sd16384) rx = -33'sd16384;
      if (ry > 33'sd16384) ry = 33'sd16384;
      if (ry < -33'sd16384) ry = -33'sd16384;
      cs_in = cmd_ff[N].neg ? -rx[15:0] : rx[15:0];
      sn_in = cmd_ff[N].neg ? -ry[15:0] : ry[15:0];
   end

   always_ff @(posedge clock) begin
      if (en[ROUND_ST]) begin
         cmd_ff[N+1] <= cmd_ff[N];
         cs_ff <= cs_in;
         sn_ff <= sn_in;
      end
   end

   // body velocities: vx, vy in Q.26, omega times radius in Q.24
   logic signed [31:0] vx_in, vy_in, vx_ff, vy_ff;
   logic signed [16:0] om_in;
   logic signed [33:0] rw_ff;
   logic signed [31:0] spd_sh, gyr_sh;

   always_comb begin
      spd_sh = 32'(cmd_ff[N+1].speed) <<< 14;
      gyr_sh = 32'(cmd_ff[N+1].gyro) <<< 14;
      vx_in = 32'sd0;
      vy_in = 32'sd0;
      om_in = 17'sd0;
      case (cmd_ff[N+1].kind)
         KIND_FWD: vx_in = spd_sh;
         KIND_BACK: vx_in = -spd_sh;
         KIND_LEFT: vy_in = spd_sh;
         KIND_RIGHT: vy_in = -spd_sh;
         KIND_CW: om_in = -17'(cmd_ff[N+1].speed);
         KIND_CCW: om_in = 17'(cmd_ff[N+1].speed);
         KIND_AIM: begin
            vx_in = spd_sh;
            vy_in = gyr_sh;
         end
         KIND_TRACK: begin
            vx_in = cmd_ff[N+1].speed * cs_ff;
            vy_in = cmd_ff[N+1].speed * sn_ff;
            om_in = 17'(cmd_ff[N+1].gyro);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en[VEL_ST]) begin
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         rw_ff <= $signed({1'b0, radius_ff}) * om_in;
      end
   end

   wheel_en_type wen;
   assign wen = '{mul: en[MUL_ST], sum: en[SUM_ST], part: en[PART_ST], fin: en[FIN_ST]};

   omwm_wheel u_wheel1 (
      .clock(clock), .en(wen), .vx(vx_ff), .vy(vy_ff), .rw(rw_ff),
      .sine(w1s_ff), .cosine(w1c_ff), .scale(scale_ff), .count(rsp_wheel1_count)
   );

   omwm_wheel u_wheel2 (
      .clock(clock), .en(wen), .vx(vx_ff), .vy(vy_ff), .rw(rw_ff),
      .sine(w2s_ff), .cosine(w2c_ff), .scale(scale_ff), .count(rsp_wheel2_count)
   );

   omwm_wheel u_wheel3 (
      .clock(clock), .en(wen), .vx(vx_ff), .vy(vy_ff), .rw(rw_ff),
      .sine(w3s_ff), .cosine(w3c_ff), .scale(scale_ff), .count(rsp_wheel3_count)
   );

   `OWM_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall, (&valid_ff))
   `OWM_ASSERT_NOW(a_fold_in_range, clock, reset, valid_ff[0], (cz_ff[0] <= Z_LIMIT && cz_ff[0] >= -Z_LIMIT))
   `OWM_ASSERT_NOW(a_drain_accepts, clock, reset, !rsp_stall, !req_stall)

endmodule

// File: sim/tb_omni_wheel_motion_mixer_core.sv
module tb_omni_wheel_motion_mixer_core;
   import omwm_pkg::*;

   localparam int LATENCY = CORDIC_STAGES + 7;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [3:0] req_kind = '0;
   logic signed [15:0] req_speed = '0;
   logic signed [15:0] req_gyro = '0;
   logic signed [15:0] req_yaw = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_wheel1_count;
   logic signed [15:0] rsp_wheel2_count;
   logic signed [15:0] rsp_wheel3_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [3:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   typedef struct {
      logic signed [15:0] w1;
      logic signed [15:0] w2;
      logic signed [15:0] w3;
   } wheel_counts_type;

   typedef struct {
      logic [3:0] kind;
      logic signed [15:0] speed;
      logic signed [15:0] gyro;
      logic signed [15:0] yaw;
      bit fixed;
      logic signed [15:0] w1;
      logic signed [15:0] w2;
      logic signed [15:0] w3;
   } cmd_row_type;

   omni_wheel_motion_mixer_core dut (.*);

   // mirrored register file
   logic signed [15:0] mount_sin [3];
   logic signed [15:0] mount_cos [3];
   logic [15:0] radius_reg;
   logic [31:0] scale_reg;

   wheel_counts_type pending_counts [$];
   int mismatches = 0;
   int cycles = 0;
   int send_idle = 0;
   int recv_idle = 0;

   initial begin
      forever begin
         #1 clock = ~clock;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp14(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic void heading_sin_cos(input logic signed [15:0] yaw,
                                           output longint sn, output longint cs);
      longint r, x, y, z, dx, dy;
      bit flip;
      longint atans [20];
      atans = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2};
      r = longint'(yaw) % 23040;
      flip = 1'b0;
      if (r < 0) r += 23040;
      if (r > 5760 && r <= 17280) begin
         r -= 11520;
         flip = 1'b1;
      end else if (r > 17280) begin
         r -= 23040;
      end
      x = 652032874;
      y = 0;
      z = r * 256;
      for (int i = 0; i < CORDIC_N; i++) begin
         dx = shr_floor(y, i);
         dy = shr_floor(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atans[i];
         end else begin
            x += dx; y -= dy; z += atans[i];
         end
      end
      x = clamp14(shr_floor(x + 32768, 16));
      y = clamp14(shr_floor(y + 32768, 16));
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endfunction

   function automatic logic signed [15:0] scale_to_count(longint w);
      bit negative;
      logic [63:0] m, mh, ml, acc, q;
      negative = w < 0;
      m = negative ? 64'(-w) : 64'(w);
      mh = m >> 24;
      ml = m & 64'hFFFFFF;
      acc = mh * 64'(scale_reg) + ((ml * 64'(scale_reg)) >> 24);
      q = acc >> 32;
      if (negative) return (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
      return (q > 32767) ? 16'sd32767 : 16'(q);
   endfunction

   function automatic wheel_counts_type mix_wheels(logic [3:0] kind,
                                                   logic signed [15:0] speed,
                                                   logic signed [15:0] gyro,
                                                   logic signed [15:0] yaw);
      longint vx, vy, om, sn, cs, rw, w;
      logic signed [15:0] c [3];
      wheel_counts_type res;
      vx = 0; vy = 0; om = 0;
      case (kind)
         KIND_FWD: vx = longint'(speed) * 16384;
         KIND_BACK: vx = -longint'(speed) * 16384;
         KIND_LEFT: vy = longint'(speed) * 16384;
         KIND_RIGHT: vy = -longint'(speed) * 16384;
         KIND_CW: om = -longint'(speed);
         KIND_CCW: om = longint'(speed);
         KIND_AIM: begin
            vx = longint'(speed) * 16384;
            vy = longint'(gyro) * 16384;
         end
         KIND_TRACK: begin
            heading_sin_cos(yaw, sn, cs);
            vx = longint'(speed) * cs;
            vy = longint'(speed) * sn;
            om = longint'(gyro);
         end
         default: ;
      endcase
      rw = longint'(radius_reg) * om * 65536;
      for (int k = 0; k < 3; k++) begin
         w = -vx * longint'(mount_sin[k]) + vy * longint'(mount_cos[k]) + rw;
         c[k] = scale_to_count(w);
      end
      res.w1 = c[0]; res.w2 = c[1]; res.w3 = c[2];
      return res;
   endfunction

   task automatic write_reg(logic [3:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_W1_SINE: mount_sin[0] = val[15:0];
         REG_W1_COSINE: mount_cos[0] = val[15:0];
         REG_W2_SINE: mount_sin[1] = val[15:0];
         REG_W2_COSINE: mount_cos[1] = val[15:0];
         REG_W3_SINE: mount_sin[2] = val[15:0];
         REG_W3_COSINE: mount_cos[2] = val[15:0];
         REG_BODY_RADIUS: radius_reg = val[15:0];
         REG_COUNT_SCALE: scale_reg = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_pipe();
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // one command transaction; idle cycles before it per the sender duty
   task automatic send_cmd(logic [3:0] kind, logic signed [15:0] speed,
                           logic signed [15:0] gyro, logic signed [15:0] yaw,
                           bit fixed, wheel_counts_type known);
      wheel_counts_type exp_counts;
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_speed <= speed;
      req_gyro <= gyro;
      req_yaw <= yaw;
      do @(posedge clock); while (req_stall);
      exp_counts = fixed ? known : mix_wheels(kind, speed, gyro, yaw);
      pending_counts.push_back(exp_counts);
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   always @(posedge clock) begin
      wheel_counts_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_counts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction");
         end else begin
            want = pending_counts.pop_front();
            if (want.w1 !== rsp_wheel1_count || want.w2 !== rsp_wheel2_count ||
                want.w3 !== rsp_wheel3_count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                           want.w1, want.w2, want.w3, rsp_wheel1_count,
                           rsp_wheel2_count, rsp_wheel3_count);
            end
         end
      end
   end

   function automatic logic signed [15:0] rand_yaw();
      case ($urandom_range(3))
         0: return 16'($urandom_range(46080)) - 16'sd23040;
         1: return 16'($urandom);
         default: return 16'($urandom_range(11520)) - 16'sd5760;
      endcase
   endfunction

   function automatic logic signed [15:0] rand_speed();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
         default: return 16'($urandom_range(8191)) - 16'sd4096;
      endcase
   endfunction

   initial begin
      cmd_row_type rows [$];
      wheel_counts_type zero_counts;
      wheel_counts_type known;
      int phase_duty [4][2];
      logic [3:0] k;
      mount_sin = '{16'sd0, 16'sd14189, -16'sd14189};
      mount_cos = '{16'sd16384, -16'sd8192, -16'sd8192};
      radius_reg = 16'd819;
      scale_reg = 32'd65536;
      zero_counts = '{16'sd0, 16'sd0, 16'sd0};
      phase_duty = '{'{0, 0}, '{46, 0}, '{0, 46}, '{30, 30}};

      rows = '{
         '{KIND_STOP, 16'sh7FFF, 16'sh7FFF, 16'sd0, 1, 0, 0, 0},
         '{4'd9, 16'sh7FFF, 16'sh8000, 16'sd100, 1, 0, 0, 0},
         '{4'd15, 16'sh8000, 16'sh7FFF, 16'sd0, 1, 0, 0, 0},
         '{KIND_FWD, 16'sd4096, 16'sd0, 16'sd0, 0, 0, 0, 0},
         '{KIND_BACK, 16'sh8000, 16'sd0, 16'sd0, 0, 0, 0, 0},
         '{KIND_LEFT, 16'sh7FFF, 16'sd0, 16'sd0, 0, 0, 0, 0},
         '{KIND_RIGHT, 16'sd4096, 16'sd0, 16'sd0, 0, 0, 0, 0},
         '{KIND_CW, 16'sh7FFF, 16'sd0, 16'sd0, 0, 0, 0, 0},
         '{KIND_CCW, 16'sh8000, 16'sd0, 16'sd0, 0, 0, 0, 0},
         '{KIND_AIM, 16'sd2048, 16'sh8000, 16'sd0, 0, 0, 0, 0},
         '{KIND_TRACK, 16'sd4096, 16'sd1000, 16'sd0, 0, 0, 0, 0},
         '{KIND_TRACK, 16'sd4096, 16'sd0, 16'sd5760, 0, 0, 0, 0},
         '{KIND_TRACK, 16'sd4096, 16'sd0, 16'sd5761, 0, 0, 0, 0},
         '{KIND_TRACK, 16'sd4096, 16'sd0, 16'sd17280, 0, 0, 0, 0},
         '{KIND_TRACK, 16'sd4096, 16'sd0, 16'sd17281, 0, 0, 0, 0},
         '{KIND_TRACK, 16'sh7FFF, 16'sh7FFF, 16'sd23040, 0, 0, 0, 0},
         '{KIND_TRACK, 16'sh8000, 16'sh8000, -16'sd23040, 0, 0, 0, 0},
         '{KIND_TRACK, 16'sd4096, 16'sd0, 16'sh7FFF, 0, 0, 0, 0},
         '{KIND_TRACK, 16'sd4096, 16'sd0, 16'sh8000, 0, 0, 0, 0},
         '{KIND_TRACK, 16'sd4096, 16'sd0, -16'sd11520, 0, 0, 0, 0}
      };

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         known.w1 = rows[i].w1; known.w2 = rows[i].w2; known.w3 = rows[i].w3;
         send_cmd(rows[i].kind, rows[i].speed, rows[i].gyro, rows[i].yaw,
                  rows[i].fixed, known);
      end
      end_burst();
      drain_pipe();

      // extremes of the registers, saturation in both directions
      write_reg(REG_COUNT_SCALE, 32'hFFFFFFFF);
      write_reg(REG_BODY_RADIUS, 32'h0000FFFF);
      write_reg(REG_W1_SINE, 32'h0000C000);
      write_reg(REG_W1_COSINE, 32'h00004000);
      write_reg(4'd12, 32'h12345678);
      send_cmd(KIND_FWD, 16'sh7FFF, 16'sd0, 16'sd0, 0, zero_counts);
      send_cmd(KIND_CCW, 16'sh7FFF, 16'sd0, 16'sd0, 1,
               '{16'sd32767, 16'sd32767, 16'sd32767});
      send_cmd(KIND_CCW, 16'sh8000, 16'sd0, 16'sd0, 1,
               '{-16'sd32768, -16'sd32768, -16'sd32768});
      end_burst();
      drain_pipe();
      write_reg(REG_COUNT_SCALE, 32'd0);
      send_cmd(KIND_AIM, 16'sh7FFF, 16'sh8000, 16'sd0, 1, zero_counts);
      end_burst();
      drain_pipe();

      for (int p = 0; p < 4; p++) begin
         for (int r = 0; r < 8; r++) begin
            k = 4'(r);
            if (r < 6) write_reg(k, (p == 1) ? 32'($urandom) :
                                    32'($urandom_range(32768)) - 32'd16384);
            else if (r == 6) write_reg(k, (p == 3) ? 32'd0 : 32'($urandom_range(65535)));
            else write_reg(k, (p == 2) ? 32'($urandom) : 32'($urandom_range(1 << 20)));
         end
         send_idle = phase_duty[p][0];
         recv_idle = phase_duty[p][1];
         for (int n = 0; n < 150; n++) begin
            k = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8));
            send_cmd(k, rand_speed(), rand_speed(), rand_yaw(), 0, zero_counts);
            if (send_idle != 0 && $urandom_range(30) == 0) end_burst();
         end
         end_burst();
         send_idle = 0;
         recv_idle = 0;
         drain_pipe();
      end

      if (mismatches == 0 && pending_counts.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
